FILE: rtl/oat_pkg.sv
// shared types and codes of the ordered array table
`default_nettype none

package oat_pkg;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_SWAP   = 3'd4,
    MODE_READ   = 3'd5,
    MODE_BACK   = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_WALK
  } fsm_e;

  typedef struct packed {
    cell_op_e op;
    logic     capture;
    logic     hit;
  } cell_ctrl_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] element_count;
    logic               is_empty;
    logic [STAT_W-1:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/oat_ifs.sv
// request and response channel interfaces
`default_nettype none

interface oat_req_if;
  import oat_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface oat_rsp_if;
  import oat_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/oat_cell.sv
// one storage cell of the element chain with its read tap
`default_nettype none

module oat_cell #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire oat_pkg::cell_ctrl_t ctrl,
  input  wire logic [WIDTH-1:0]   bus,
  input  wire logic [WIDTH-1:0]   prev,
  input  wire logic [WIDTH-1:0]   next,
  output logic      [WIDTH-1:0]   data,
  output logic      [WIDTH-1:0]   tap
);
  import oat_pkg::*;

  logic hit;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_LOAD: data <= bus;
      CELL_PREV: data <= prev;
      CELL_NEXT: data <= next;
      default:   data <= data;
    endcase
  end

  // read select, held until the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.capture) begin
      hit <= ctrl.hit;
    end
  end

  assign tap = hit ? data : '0;

endmodule

`default_nettype wire

FILE: rtl/oat_read_tree.sv
// registered radix-4 or-tree that collects the selected cell
`default_nettype none

module oat_read_tree #(
  parameter int WIDTH  = 32,
  parameter int LEAVES = 64
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] leaf [LEAVES],
  output logic      [WIDTH-1:0] root
);

  localparam int LVLS  = ($clog2(LEAVES) + 1) / 2;
  localparam int NL    = 1 << (2 * LVLS);
  localparam int NODES = (NL - 1) / 3;

  logic [WIDTH-1:0] node [NODES];
  logic [WIDTH-1:0] pad  [NL];

  for (genvar j = 0; j < NL; j++) begin : g_pad
    if (j < LEAVES) begin : g_real
      assign pad[j] = leaf[j];
    end else begin : g_zero
      assign pad[j] = '0;
    end
  end

  // heap order: children of node n are 4n+1 .. 4n+4
  for (genvar n = 0; n < NODES; n++) begin : g_node
    logic [WIDTH-1:0] kid [4];
    for (genvar k = 0; k < 4; k++) begin : g_kid
      localparam int C = 4 * n + 1 + k;
      if (C < NODES) begin : g_inner
        assign kid[k] = node[C];
      end else begin : g_leaf
        assign kid[k] = pad[C - NODES];
      end
    end
    always_ff @(posedge clk) begin
      node[n] <= kid[0] | kid[1] | kid[2] | kid[3];
    end
  end

  assign root = node[0];

endmodule

`default_nettype wire

FILE: rtl/ordered_array_table_unit.sv
// top level of the ordered array table: cell chain, read tree and control
//
// usage
//   req channel carries one request: mode, index and value. rsp channel returns
//   one response for every request: read_value, element_count, is_empty, status.
//   both channels are valid/ready, a transfer happens when both are high.
// operation
//   the array lives in a chain of CAPACITY cells. insert and erase move every
//   affected cell from its neighbor at the accept edge, whatever the shift's
//   length; push loads only the cell at the count. reads (and the back fetch
//   of a swap-remove) go through a registered radix-4 or-tree of L levels,
//   L = ceil(log4(CAPACITY)). every request takes the same path: the sequencer
//   walks the tree, the result goes into the output register, and only then
//   is the next request taken. the or-tree depth sets the length of the walk.
// reset
//   rst is synchronous: element count goes to zero, rsp.valid drops and req.ready rises.
//   cell contents are not cleared; only written cells are ever read.
// stall
//   the response sits in an output register; a new request is taken while it
//   waits. if the next response is done before the old one is taken, the
//   block holds with the tree result until rsp.ready comes.
`default_nettype none

module ordered_array_table_unit #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  oat_req_if.sink   req,
  oat_rsp_if.source rsp
);
  import oat_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int LVLS = ($clog2(CAPACITY) + 1) / 2;
  localparam int WCW  = $clog2(LVLS + 1);
  localparam int EW   = ELEMENT_WIDTH;

  // control state
  fsm_e           state, state_next;
  logic [WCW-1:0] wcnt, wcnt_next;
  logic [CW-1:0]  count, count_next;
  logic           done;
  logic           acc;

  // per-request context kept during the tree walk
  logic [STAT_W-1:0] status_q;
  logic              rv_en_q;
  logic              swap_q;
  logic [IW-1:0]     sw_idx;

  // decode results
  status_e       st;
  logic          op_push, op_ins, op_era, op_swap;
  logic          rd_en, rv_en;
  logic [IW-1:0] rd_addr;

  logic [IW-1:0] idx_x, cnt_x, cnt_m1;
  logic          full, empty;

  logic [EW-1:0] val_e;
  logic [EW-1:0] bus;
  logic [EW-1:0] root;
  logic [EW-1:0] cell_data [CAPACITY];
  logic [EW-1:0] cell_tap  [CAPACITY];

  logic out_valid;
  rsp_t out_payload;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == FSM_IDLE);

  assign idx_x  = IW'(req.payload.index);
  assign cnt_x  = IW'(count);
  assign cnt_m1 = cnt_x - IW'(1);
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);
  assign val_e  = EW'(req.payload.value);

  // request decode against the current count
  always_comb begin
    st         = ST_OK;
    op_push    = 1'b0;
    op_ins     = 1'b0;
    op_era     = 1'b0;
    op_swap    = 1'b0;
    rd_en      = 1'b0;
    rv_en      = 1'b0;
    rd_addr    = idx_x;
    count_next = count;
    case (req.payload.mode)
      MODE_PUSH: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          op_push    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      MODE_INSERT: begin
        // range is checked before full
        if (idx_x > cnt_x) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          op_ins     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      MODE_ERASE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          st = ST_RANGE;
        end else begin
          op_era     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      MODE_SWAP: begin
        // fetch the back element now, write it into the hole when the tree is done
        if (empty) begin
          st = ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          st = ST_RANGE;
        end else begin
          op_swap    = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = cnt_m1;
          count_next = count - CW'(1);
        end
      end
      MODE_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          st = ST_RANGE;
        end else begin
          rd_en = 1'b1;
          rv_en = 1'b1;
        end
      end
      MODE_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rv_en   = 1'b1;
          rd_addr = cnt_m1;
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
  end

  // sequencer: idle, then walk the tree until the root is ready and the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      wcnt  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
      if (acc) begin
        count <= count_next;
      end
    end
  end

  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    done       = 1'b0;
    case (state)
      FSM_IDLE: begin
        if (acc) begin
          state_next = FSM_WALK;
          wcnt_next  = WCW'(LVLS);
        end
      end
      FSM_WALK: begin
        if (wcnt != '0) begin
          wcnt_next = wcnt - WCW'(1);
        end else if (!out_valid || rsp.ready) begin
          // root holds the selected cell, output register is free
          done       = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_q <= st;
      rv_en_q  <= rv_en;
      swap_q   <= op_swap;
      sw_idx   <= idx_x;
    end
  end

  // data bus into the cells: request value at accept, tree result for swap
  assign bus = (state == FSM_WALK) ? root : val_e;

  // cell chain with per-position control
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [IW-1:0] POS = IW'(g);
    cell_ctrl_t    ctrl;
    logic [EW-1:0] prev, next;

    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_prev
      assign prev = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next = '0;
    end else begin : g_next
      assign next = cell_data[g+1];
    end

    always_comb begin
      ctrl.op      = CELL_HOLD;
      ctrl.capture = acc;
      ctrl.hit     = rd_en && (POS == rd_addr);
      if (acc && op_push && POS == cnt_x) begin
        ctrl.op = CELL_LOAD;
      end else if (acc && op_ins && POS == idx_x) begin
        ctrl.op = CELL_LOAD;
      end else if (acc && op_ins && POS > idx_x && POS <= cnt_x) begin
        // open the gap: take the lower neighbor
        ctrl.op = CELL_PREV;
      end else if (acc && op_era && POS >= idx_x && POS < cnt_m1) begin
        // close the gap: take the upper neighbor
        ctrl.op = CELL_NEXT;
      end else if (done && swap_q && POS == sw_idx) begin
        ctrl.op = CELL_LOAD;
      end
    end

    oat_cell #(
      .WIDTH(EW)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .bus  (bus),
      .prev (prev),
      .next (next),
      .data (cell_data[g]),
      .tap  (cell_tap[g])
    );
  end

  oat_read_tree #(
    .WIDTH  (EW),
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_tap),
    .root (root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_payload.read_value    <= rv_en_q ? VALUE_W'(root) : '0;
      out_payload.element_count <= COUNT_W'(count);
      out_payload.is_empty      <= empty;
      out_payload.status        <= status_q;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_payload;

endmodule

`default_nettype wire

FILE: rtl/oat_checker.sv
// port-level checks of the ordered array table and their bind
`default_nettype none

module oat_port_checks #(
  parameter int CAPACITY = 64
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire oat_pkg::rsp_t rsp_payload
);
  import oat_pkg::*;

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> int'(rsp_payload.element_count) <= CAPACITY)
    else $error("element count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_payload.is_empty == (rsp_payload.element_count == '0))
    else $error("empty flag disagrees with count");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.read_value == '0)
    else $error("rejected request returned data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("stalled response changed");

endmodule

bind ordered_array_table_unit oat_port_checks #(
  .CAPACITY(CAPACITY)
) u_oat_port_checks (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

`default_nettype wire
